// ===== rtl/mavg_pkg.sv =====
package mavg_pkg;

    // Width of the window size register.
    localparam int WSIZE_WIDTH = 9;

    // Window size after reset.
    localparam logic [WSIZE_WIDTH-1:0] WSIZE_RESET = 9'd4;

    // Guard bits of the window sum above the sample width.
    localparam int SUM_GUARD_BITS = 8;

    // Control from the sequencer to the divider.
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    // Status from the divider to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== rtl/mavg_sample_if.sv =====
interface mavg_sample_if #(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           first_of_series;

    modport source (output valid, output sample, output first_of_series, input ready);
    modport sink (input valid, input sample, input first_of_series, output ready);
endinterface

// ===== rtl/mavg_average_if.sv =====
interface mavg_average_if #(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink (input valid, input average, output ready);
endinterface

// ===== rtl/mavg_window_store.sv =====
module mavg_window_store #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port; a read at the same address returns the old entry.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mavg_divider.sv =====
module mavg_divider #(
    parameter int DIVIDEND_WIDTH = 40
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mavg_pkg::div_ctrl_t                 ctrl,
    input  logic signed [DIVIDEND_WIDTH-1:0]    dividend,
    input  logic [mavg_pkg::WSIZE_WIDTH-1:0]    divisor,
    output mavg_pkg::div_status_t               status,
    output logic signed [DIVIDEND_WIDTH-1:0]    quotient
);

    localparam int DW = DIVIDEND_WIDTH;
    localparam int RW = mavg_pkg::WSIZE_WIDTH;
    localparam int CNTW = $clog2(DW);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] count_reg;
    logic [DW-1:0]   quo_reg;
    logic [RW-1:0]   rem_reg;
    logic [RW-1:0]   divisor_reg;
    logic            neg_reg;

    logic [DW-1:0]   magnitude;
    logic [RW:0]     trial;
    logic [RW:0]     trial_diff;
    logic            trial_ge;
    logic [RW-1:0]   rem_next;

    // Magnitude of the dividend; the most negative value still fits unsigned.
    assign magnitude = dividend[DW-1] ? (~dividend + 1'b1) : dividend;

    // One restoring step: shift in the next dividend bit and try the divisor.
    always_comb
    begin
        trial      = {rem_reg, quo_reg[DW-1]};
        trial_diff = trial - {1'b0, divisor_reg};
        trial_ge   = (trial >= {1'b0, divisor_reg});
        rem_next   = trial_ge ? trial_diff[RW-1:0] : trial[RW-1:0];
    end

    // Control: busy for one cycle per quotient bit, then a done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (count_reg == CNTW'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            quo_reg     <= magnitude;
            rem_reg     <= '0;
            divisor_reg <= divisor;
            neg_reg     <= dividend[DW-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], trial_ge};
            rem_reg <= rem_next;
        end
    end

    // Sign is restored after the magnitude division, so truncation is toward zero.
    assign quotient    = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== rtl/moving_average_filter_unit.sv =====
// Channel          Modport   Payload                     Role
// sample_stream    sink      sample, first_of_series     one sample per item
// average_stream   source    average                     one window mean per item
// window_size_*    write     window_size (9 bits)        samples in the window
//
// A sample that gives a result runs through the bit-serial divider; one that does
// not goes back to idle from the subtract step.
// One item is in work at a time; sample_stream.ready is high only when idle.
// The result sits in an output register, so the next sample may be taken while
// it waits; a later result stays in the result state until that register frees.
// The window store and the datapath registers have no reset; the control and
// series registers clear on rst_n.
module moving_average_filter_unit #(
    parameter int MAX_WINDOW   = 256,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    mavg_sample_if.sink                      sample_stream,
    mavg_average_if.source                   average_stream,
    input  logic                             window_size_we,
    input  logic [mavg_pkg::WSIZE_WIDTH-1:0] window_size_data
);

    localparam int WSW     = mavg_pkg::WSIZE_WIDTH;
    localparam int SUM_W   = SAMPLE_WIDTH + mavg_pkg::SUM_GUARD_BITS;
    localparam int PW      = $clog2(MAX_WINDOW);
    localparam int CW      = $clog2(MAX_WINDOW + 1);
    localparam int AW      = ((PW > WSW) ? PW : WSW) + 1;
    localparam int CMPW    = ((CW > WSW) ? CW : WSW) + 1;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SUB   = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [WSW-1:0]          window_size_reg;
    logic [PW-1:0]           wp_reg;
    logic [CW-1:0]           seen_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    do_sub_reg;
    logic                    do_out_reg;
    logic signed [SAMPLE_WIDTH-1:0] avg_reg;
    logic                    out_valid_reg;

    logic                    accept;
    logic                    out_load;
    logic [WSW-1:0]          w_eff;
    logic [CW-1:0]           old_count;
    logic [CMPW-1:0]         old_ext;
    logic [CMPW-1:0]         w_cmp;
    logic [AW-1:0]           wp_ext;
    logic [AW-1:0]           w_ext;
    logic [AW-1:0]           idx_ext;
    logic [SAMPLE_WIDTH-1:0] leaving;
    logic signed [SUM_W-1:0] add_a;
    logic signed [SUM_W-1:0] add_b;
    logic                    add_sub;
    logic signed [SUM_W-1:0] add_result;
    logic signed [SUM_W-1:0] quotient;
    logic [SUM_W-SAMPLE_WIDTH:0] q_upper;
    logic signed [SAMPLE_WIDTH-1:0] q_sat;

    mavg_pkg::div_ctrl_t     div_ctrl;
    mavg_pkg::div_status_t   div_status;

    assign accept = sample_stream.valid && sample_stream.ready;
    assign sample_stream.ready = (state_reg == S_IDLE);

    // Window size register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= mavg_pkg::WSIZE_RESET;
        end
        else if (window_size_we)
        begin
            window_size_reg <= window_size_data;
        end
    end

    // Effective window, limited to the store depth.
    assign w_eff = (32'(window_size_reg) > MAX_WINDOW) ? WSW'(MAX_WINDOW) : window_size_reg;

    // Count of the series before this sample, and the address of the leaving sample.
    always_comb
    begin
        old_count = sample_stream.first_of_series ? '0 : seen_reg;
        old_ext   = CMPW'(old_count);
        w_cmp     = CMPW'(w_eff);
        wp_ext    = AW'(wp_reg);
        w_ext     = AW'(w_eff);
        if (wp_ext >= w_ext)
        begin
            idx_ext = wp_ext - w_ext;
        end
        else
        begin
            idx_ext = wp_ext + AW'(MAX_WINDOW) - w_ext;
        end
    end

    mavg_window_store #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (SAMPLE_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata (sample_stream.sample),
        .re    (accept),
        .raddr (idx_ext[PW-1:0]),
        .rdata (leaving)
    );

    // Shared sum adder: adds the new sample on accept, subtracts the leaving one after.
    always_comb
    begin
        if (state_reg == S_SUB)
        begin
            add_a   = sum_reg;
            add_b   = SUM_W'($signed(leaving));
            add_sub = 1'b1;
        end
        else
        begin
            add_a   = sample_stream.first_of_series ? '0 : sum_reg;
            add_b   = SUM_W'(sample_stream.sample);
            add_sub = 1'b0;
        end
        add_result = add_sub ? (add_a - add_b) : (add_a + add_b);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                state_next = do_out_reg ? S_START : S_IDLE;
            end
            S_START:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || average_stream.ready);

    // Sequencer and series state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            seen_reg      <= '0;
            sum_reg       <= '0;
            do_sub_reg    <= 1'b0;
            do_out_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                sum_reg    <= add_result;
                wp_reg     <= (wp_reg == PW'(MAX_WINDOW - 1)) ? '0 : wp_reg + 1'b1;
                seen_reg   <= (32'(old_count) >= MAX_WINDOW) ? CW'(MAX_WINDOW)
                                                             : old_count + 1'b1;
                do_sub_reg <= (w_eff != '0) && (old_ext >= w_cmp);
                do_out_reg <= (w_eff != '0) && ((old_ext + 1'b1) >= w_cmp);
            end
            else if ((state_reg == S_SUB) && do_sub_reg)
            begin
                sum_reg <= add_result;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (average_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign div_ctrl.start = (state_reg == S_START);

    mavg_divider #(
        .DIVIDEND_WIDTH (SUM_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (sum_reg),
        .divisor  (w_eff),
        .status   (div_status),
        .quotient (quotient)
    );

    // Saturate the quotient to the sample range.
    always_comb
    begin
        q_upper = quotient[SUM_W-1:SAMPLE_WIDTH-1];
        if ((&q_upper) || !(|q_upper))
        begin
            q_sat = quotient[SAMPLE_WIDTH-1:0];
        end
        else if (quotient[SUM_W-1])
        begin
            q_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end
        else
        begin
            q_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            avg_reg <= q_sat;
        end
    end

    assign average_stream.valid   = out_valid_reg;
    assign average_stream.average = avg_reg;

    // The divider is never running while a new item can be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stream.ready |-> !div_status.busy)
        else $error("divider busy while the block is ready");

    // An accepted item always moves on to the subtract step.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_SUB))
        else $error("accepted item did not reach the subtract step");

    // While waiting on the divider it is either running or just finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_status.busy || div_status.done))
        else $error("waiting on an idle divider");

    // A new result appears only from the result state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result shown without a finished division");

endmodule
